// ===== hw/rtl/servo_status_packet_parser_unit_defines.svh =====
// Assertion helpers shared by the parser RTL.
// Each macro expects the enclosing module to have clk and arst_n.
`ifndef SERVO_STATUS_PACKET_PARSER_UNIT_DEFINES_SVH
`define SERVO_STATUS_PACKET_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define SSPP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sspp check failed");

// Next-cycle implication, held off during reset.
`define SSPP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sspp check failed");

`endif

// ===== hw/rtl/sspp_pkg.sv =====
`default_nettype none
package sspp_pkg;

	localparam logic [7:0] HDR_BYTE   = 8'hFF;
	localparam int         WIN_DEPTH  = 7;
	localparam int         CFG_IDX_W  = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PAN_ID  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TILT_ID = 2'd1;

	// matched_servo codes
	localparam logic [1:0] MATCH_PAN  = 2'd0;
	localparam logic [1:0] MATCH_TILT = 2'd1;
	localparam logic [1:0] MATCH_NONE = 2'd2;

	// frame check result handed from window to result stage
	typedef struct packed {
		logic        hit;
		logic [7:0]  id;
		logic [15:0] pos;
	} frame_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sspp_window.sv =====
`default_nettype none
`include "servo_status_packet_parser_unit_defines.svh"
module sspp_window (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            advance,
	input  wire logic [7:0]      rx_byte_s1,
	output sspp_pkg::frame_t     frame
);
	import sspp_pkg::*;

	logic [7:0] win_q [WIN_DEPTH];
	logic [7:0] sum;

	// checksum over id, length, error and position bytes
	always_comb begin
		sum = win_q[2] + win_q[3] + win_q[4] + win_q[5] + win_q[6];
		frame.hit = (win_q[0] == HDR_BYTE) && (win_q[1] == HDR_BYTE) && (rx_byte_s1 == ~sum);
		frame.id  = win_q[2];
		frame.pos = {win_q[6], win_q[5]};
	end

	// sliding window: shift in the new byte, clear after a good frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN_DEPTH; i++) win_q[i] <= '0;
		end else if (advance) begin
			if (frame.hit) begin
				for (int i = 0; i < WIN_DEPTH; i++) win_q[i] <= '0;
			end else begin
				for (int i = 0; i < WIN_DEPTH - 1; i++) win_q[i] <= win_q[i+1];
				win_q[WIN_DEPTH-1] <= rx_byte_s1;
			end
		end
	end

	// a good frame leaves no header behind
	`SSPP_ASSERT_NEXT(a_clear_after_hit, advance && frame.hit, win_q[0] == '0 && win_q[1] == '0)
	// window only moves on an advance
	`SSPP_ASSERT_NEXT(a_hold_idle, !advance, win_q[6] == $past(win_q[6]))

endmodule
`default_nettype wire

// ===== hw/rtl/sspp_result.sv =====
`default_nettype none
`include "servo_status_packet_parser_unit_defines.svh"
module sspp_result (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             take,
	input  wire sspp_pkg::frame_t frame,
	input  wire logic [7:0]       pan_id,
	input  wire logic [7:0]       tilt_id,
	input  wire logic             out_ready,
	output logic                  out_valid,
	output logic                  out_free,
	output logic [7:0]            frame_id,
	output logic [15:0]           frame_position,
	output logic [1:0]            matched_servo,
	output logic [15:0]           pan_position,
	output logic [15:0]           tilt_position
);
	import sspp_pkg::*;

	logic [1:0]  match;
	logic [15:0] pan_nx;
	logic [15:0] tilt_nx;
	logic [15:0] pan_q;
	logic [15:0] tilt_q;
	logic        out_valid_q;
	logic [7:0]  id_q;
	logic [15:0] pos_q;
	logic [1:0]  match_q;
	logic [15:0] pan_out_q;
	logic [15:0] tilt_out_q;

	// id match, pan wins on a tie
	always_comb begin
		pan_nx  = pan_q;
		tilt_nx = tilt_q;
		if (frame.id == pan_id) begin
			match  = MATCH_PAN;
			pan_nx = frame.pos;
		end else if (frame.id == tilt_id) begin
			match   = MATCH_TILT;
			tilt_nx = frame.pos;
		end else begin
			match = MATCH_NONE;
		end
	end

	// stored present positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pan_q  <= '0;
			tilt_q <= '0;
		end else if (take) begin
			pan_q  <= pan_nx;
			tilt_q <= tilt_nx;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (take) begin
			id_q       <= frame.id;
			pos_q      <= frame.pos;
			match_q    <= match;
			pan_out_q  <= pan_nx;
			tilt_out_q <= tilt_nx;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_free       = !out_valid_q || out_ready;
	assign frame_id       = id_q;
	assign frame_position = pos_q;
	assign matched_servo  = match_q;
	assign pan_position   = pan_out_q;
	assign tilt_position  = tilt_out_q;

	// never overwrite a request still waiting
	`SSPP_ASSERT_NOW(a_no_overwrite, take, out_free)
	// a pan match lands in the pan store
	`SSPP_ASSERT_NEXT(a_pan_store, take && match == MATCH_PAN, pan_q == $past(frame.pos))
	// reported positions agree with the stores
	`SSPP_ASSERT_NOW(a_out_stores, out_valid_q && !take,
		pan_out_q == pan_q && tilt_out_q == tilt_q)

endmodule
`default_nettype wire

// ===== hw/rtl/servo_status_packet_parser_unit.sv =====
// Servo status packet parser. Bus bytes enter on the rx_byte channel, one
// request per cycle unless stalled; each byte is registered, then checked
// against the last seven bytes for a status frame (two 0xFF headers,
// checksum in the eighth byte). A good frame presents one result request
// through the input register and then the result register, carrying id,
// position, which servo matched and both stored positions; other bytes give
// no result. The sustained rate is one byte per cycle while no good frame
// meets a full result register, set by the window shift and checksum loop.
// A finishing frame waits only while the result register still holds an
// untaken request. Id registers should be written while no byte is in flight.
`default_nettype none
`include "servo_status_packet_parser_unit_defines.svh"
module servo_status_packet_parser_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [7:0]                    rx_byte,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [sspp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]                    cfg_data,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [7:0]                         frame_id,
	output logic [15:0]                        frame_position,
	output logic [1:0]                         matched_servo,
	output logic [15:0]                        pan_position,
	output logic [15:0]                        tilt_position
);
	import sspp_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic [7:0] pan_id_q;
	logic [7:0] tilt_id_q;
	logic       out_free;
	logic       s1_go;
	frame_t     frame;

	// id registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pan_id_q  <= 8'd1;
			tilt_id_q <= 8'd2;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PAN_ID:  pan_id_q  <= cfg_data;
				REG_TILT_ID: tilt_id_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage one moves on unless a good frame meets a full result register
	assign s1_go    = valid_s1 && (!frame.hit || out_free);
	assign in_ready = !valid_s1 || s1_go;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) byte_s1 <= rx_byte;
	end

	sspp_window u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (s1_go),
		.rx_byte_s1 (byte_s1),
		.frame      (frame)
	);

	sspp_result u_result (
		.clk            (clk),
		.arst_n         (arst_n),
		.take           (s1_go && frame.hit),
		.frame          (frame),
		.pan_id         (pan_id_q),
		.tilt_id        (tilt_id_q),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.out_free       (out_free),
		.frame_id       (frame_id),
		.frame_position (frame_position),
		.matched_servo  (matched_servo),
		.pan_position   (pan_position),
		.tilt_position  (tilt_position)
	);

	// an empty input stage always takes a byte
	`SSPP_ASSERT_NOW(a_ready_when_empty, !valid_s1, in_ready)
	// a blocked frame holds the input side
	`SSPP_ASSERT_NOW(a_block_on_full, valid_s1 && frame.hit && !out_free, !in_ready)
	// a completed frame shows up as a result next cycle
	`SSPP_ASSERT_NEXT(a_result_follows, s1_go && frame.hit, out_valid)

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`default_nettype none
module testbench;
	import sspp_pkg::*;

	// index values outside the register list; writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	localparam int MAX_GAP        = 18;
	localparam int SETTLE_CYCLES  = 8;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASES         = 8;
	localparam int PHASE_BYTES    = 225;
	localparam int DIR_ROWS       = 28;

	typedef struct packed {
		logic [7:0]  id;
		logic [15:0] pos;
		logic [1:0]  which;
		logic [15:0] pan;
		logic [15:0] tilt;
	} status_rec_t;

	typedef enum logic {ROW_BYTE, ROW_REG} row_kind_t;

	typedef struct packed {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   idx;
		logic [7:0]             val;
		logic                   typed;
		status_rec_t            st;
	} dir_row_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [7:0]           rx_byte = 8'h00;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_PAN_ID;
	logic [7:0]           cfg_data = 8'h00;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [7:0]           frame_id;
	logic [15:0]          frame_position;
	logic [1:0]           matched_servo;
	logic [15:0]          pan_position;
	logic [15:0]          tilt_position;

	// hand-typed expectation that travels with the byte request
	logic                 row_typed = 1'b0;
	status_rec_t          row_status = '0;

	// predictor state
	logic [7:0]           win [0:6];
	logic [7:0]           pan_id;
	logic [7:0]           tilt_id;
	logic [15:0]          pan_pos;
	logic [15:0]          tilt_pos;
	status_rec_t          pending_status [$];

	int                   errors = 0;
	int                   bytes_offered = 0;
	int                   results_checked = 0;
	int                   reg_writes = 0;
	int                   quiet_cycles = 0;
	logic                 tx_calm = 1'b0;
	logic                 rx_calm = 1'b0;
	logic                 rx_hold_req = 1'b0;

	dir_row_t             dir_table [DIR_ROWS];

	servo_status_packet_parser_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.rx_byte        (rx_byte),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.frame_id       (frame_id),
		.frame_position (frame_position),
		.matched_servo  (matched_servo),
		.pan_position   (pan_position),
		.tilt_position  (tilt_position)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// predictor: shift one bus byte into the window, queue a status if it closes a frame
	task automatic parse_rx_byte(input logic [7:0] b, input logic typed, input status_rec_t st);
		logic [7:0]  sum;
		status_rec_t s;
		sum = win[2] + win[3] + win[4] + win[5] + win[6];
		if (win[0] == HDR_BYTE && win[1] == HDR_BYTE && b == ~sum) begin
			s.id  = win[2];
			s.pos = {win[6], win[5]};
			if (win[2] == pan_id) begin
				pan_pos = s.pos;
				s.which = MATCH_PAN;
			end else if (win[2] == tilt_id) begin
				tilt_pos = s.pos;
				s.which = MATCH_TILT;
			end else begin
				s.which = MATCH_NONE;
			end
			s.pan  = pan_pos;
			s.tilt = tilt_pos;
			for (int k = 0; k < 7; k++)
				win[k] = 8'h00;
			pending_status.push_back(typed ? st : s);
		end else begin
			for (int k = 0; k < 6; k++)
				win[k] = win[k + 1];
			win[6] = b;
		end
	endtask

	initial begin
		pan_id   = 8'd1;
		tilt_id  = 8'd2;
		pan_pos  = '0;
		tilt_pos = '0;
		for (int k = 0; k < 7; k++)
			win[k] = 8'h00;
	end

	// byte requests taken by the block
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			parse_rx_byte(rx_byte, row_typed, row_status);
	end

	// id register writes taken by the block
	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready) begin
			reg_writes++;
			case (cfg_index)
				REG_PAN_ID:  pan_id = cfg_data;
				REG_TILT_ID: tilt_id = cfg_data;
				default: ;
			endcase
		end
	end

	task automatic check_field(input string what, input logic [15:0] want, input logic [15:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %h got %h", $time, what, want, got);
		end
	endtask

	// result requests against the oldest waiting status
	always @(posedge clk) begin : status_check
		status_rec_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_status.size() == 0) begin
				errors++;
				$display("%0t: unexpected status, expected none got id %h pos %h match %0d",
					$time, frame_id, frame_position, matched_servo);
			end else begin
				want = pending_status.pop_front();
				results_checked++;
				check_field("frame_id", 16'(want.id), 16'(frame_id));
				check_field("frame_position", want.pos, frame_position);
				check_field("matched_servo", 16'(want.which), 16'(matched_servo));
				check_field("pan_position", want.pan, pan_position);
				check_field("tilt_position", want.tilt, tilt_position);
			end
		end
	end

	// no request moving on any channel for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog, %0d statuses still outstanding", $time, pending_status.size());
			$display("testbench: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// status receiver: random stalls, quiet stretches, one long hold when asked
	initial begin : status_sink
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (rx_hold_req) begin
				out_ready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
				rx_hold_req = 1'b0;
			end else begin
				stall = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
				if (stall > 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic typed, input status_rec_t st);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		rx_byte    <= b;
		row_typed  <= typed;
		row_status <= st;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		bytes_offered++;
	endtask

	// leave valid high after the write; caller drops it once the batch is done
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	// stop sending, let every status drain, then allow the pipe to empty
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_status.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// a status frame, optionally cut short or with one byte spoilt
	task automatic send_frame(input logic [7:0] id, input logic [15:0] pos, input int cut,
			input int bad_at, input logic [7:0] bad_mask);
		logic [7:0] fb [8];
		fb[0] = HDR_BYTE;
		fb[1] = HDR_BYTE;
		fb[2] = id;
		fb[3] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h04;
		fb[4] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00;
		fb[5] = pos[7:0];
		fb[6] = pos[15:8];
		fb[7] = ~(fb[2] + fb[3] + fb[4] + fb[5] + fb[6]);
		if (bad_at < 8)
			fb[bad_at] = fb[bad_at] ^ bad_mask;
		for (int k = 0; k < cut; k++)
			send_byte(fb[k], 1'b0, '0);
	endtask

	function automatic dir_row_t byte_row(input logic [7:0] b);
		dir_row_t r;
		r = '0;
		r.kind = ROW_BYTE;
		r.val = b;
		return r;
	endfunction

	function automatic dir_row_t end_row(input logic [7:0] b, input status_rec_t st);
		dir_row_t r;
		r = byte_row(b);
		r.typed = 1'b1;
		r.st = st;
		return r;
	endfunction

	function automatic dir_row_t reg_row(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] v);
		dir_row_t r;
		r = '0;
		r.kind = ROW_REG;
		r.idx = idx;
		r.val = v;
		return r;
	endfunction

	initial begin : stimulus
		logic [7:0]  p_sel;
		logic [7:0]  t_sel;
		logic [7:0]  id;
		logic [15:0] pos;
		int          pick;
		int          phase_end;
		int          n;

		// pan frame at position zero, then tilt at full scale straight after the clear;
		// then both ids set to 0xFF (above range, equal) so pan wins; spare indexes dropped
		dir_table = '{
			byte_row(HDR_BYTE), byte_row(HDR_BYTE), byte_row(8'h01), byte_row(8'h04),
			byte_row(8'h00), byte_row(8'h00), byte_row(8'h00),
			end_row(8'hFA, status_rec_t'{8'h01, 16'h0000, MATCH_PAN, 16'h0000, 16'h0000}),
			byte_row(HDR_BYTE), byte_row(HDR_BYTE), byte_row(8'h02), byte_row(8'h04),
			byte_row(8'h00), byte_row(8'hFF), byte_row(8'hFF),
			end_row(8'hFB, status_rec_t'{8'h02, 16'hFFFF, MATCH_TILT, 16'h0000, 16'hFFFF}),
			reg_row(REG_PAN_ID, 8'hFF), reg_row(REG_TILT_ID, 8'hFF),
			reg_row(REG_SPARE_2, 8'h00), reg_row(REG_SPARE_3, 8'h00),
			byte_row(HDR_BYTE), byte_row(HDR_BYTE), byte_row(8'hFF), byte_row(8'hFF),
			byte_row(8'hFF), byte_row(8'h34), byte_row(8'h12),
			end_row(8'hBC, status_rec_t'{8'hFF, 16'h1234, MATCH_PAN, 16'h1234, 16'hFFFF})
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows
		for (int r = 0; r < DIR_ROWS; r++) begin
			if (dir_table[r].kind == ROW_REG) begin
				if (!cfg_valid)
					wait_idle();
				write_reg(dir_table[r].idx, dir_table[r].val);
			end else begin
				if (cfg_valid)
					cfg_valid <= 1'b0;
				send_byte(dir_table[r].val, dir_table[r].typed, dir_table[r].st);
			end
		end

		// random phases, each with its own id setting
		for (int ph = 0; ph < PHASES; ph++) begin
			wait_idle();
			case (ph)
				0: begin p_sel = 8'd0;   t_sel = 8'd253; end
				1: begin p_sel = 8'd253; t_sel = 8'd0;   end
				2: begin p_sel = 8'd7;   t_sel = 8'd7;   end
				3: begin p_sel = 8'd254; t_sel = 8'd255; end
				5: begin p_sel = 8'd255; t_sel = 8'd255; end
				default: begin
					p_sel = 8'($urandom_range(0, 253));
					t_sel = 8'($urandom_range(0, 253));
				end
			endcase
			write_reg(REG_PAN_ID, p_sel);
			write_reg(REG_TILT_ID, t_sel);
			if (ph % 2 == 1) begin
				write_reg(REG_SPARE_2, 8'($urandom));
				write_reg(REG_SPARE_3, 8'($urandom));
			end
			cfg_valid <= 1'b0;

			tx_calm = (ph == 2 || ph == 4 || ph == 6);
			rx_calm = (ph == 2 || ph == 6);
			// sender keeps going while the receiver sits on its results
			if (ph == 4)
				rx_hold_req = 1'b1;

			phase_end = bytes_offered + PHASE_BYTES;
			while (bytes_offered < phase_end) begin
				pick = $urandom_range(0, 99);
				n = $urandom_range(0, 9);
				id = (n < 4) ? p_sel : (n < 7) ? t_sel : 8'($urandom);
				n = $urandom_range(0, 9);
				pos = (n == 0) ? 16'h0000 : (n == 1) ? 16'hFFFF : 16'($urandom);
				if (pick < 70) begin
					send_frame(id, pos, 8, 8, 8'h00);
				end else if (pick < 80) begin
					send_frame(id, pos, 8, $urandom_range(0, 7), 8'($urandom_range(1, 255)));
				end else if (pick < 90) begin
					n = $urandom_range(1, 6);
					for (int k = 0; k < n; k++)
						send_byte(($urandom_range(0, 3) == 0) ? HDR_BYTE : 8'($urandom), 1'b0, '0);
				end else begin
					send_frame(id, pos, $urandom_range(1, 7), 8, 8'h00);
				end
			end
		end

		tx_calm = 1'b0;
		rx_calm = 1'b0;
		wait_idle();
		if (pending_status.size() != 0) begin
			errors++;
			$display("%0t: %0d statuses never arrived", $time, pending_status.size());
		end

		$display("run: %0d bus bytes, %0d status frames compared, %0d id register writes",
			bytes_offered, results_checked, reg_writes);
		$display("run: ids 0/253/254/255 and equal pan/tilt, spoilt and cut frames, long output hold");
		if (errors == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/sspp_pkg.sv
hw/rtl/sspp_window.sv
hw/rtl/sspp_result.sv
hw/rtl/servo_status_packet_parser_unit.sv
sim/testbench.sv
